### sv/lav_pkg.sv
// Shared types and constants for the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;

	localparam int WORD_W     = 32;
	localparam int MAG_W      = WORD_W + 1;
	localparam int NORM_W     = 30;
	localparam int NORM_MSB   = NORM_W - 1;
	localparam int ROOT_W     = 31;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SQRT_STEPS = ROOT_W;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [MAG_W-1:0]  wide_t;
	typedef logic [1:0]               row_t;

	localparam row_t ROW_LAST = 2'd3;

	localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

endpackage

### sv/lav_req_if.sv
// Request channel: eye and target points.
`timescale 1ns / 1ps
interface lav_req_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] aim_x;
	logic signed [31:0] aim_y;
	logic signed [31:0] aim_z;

	modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, input ready);
	modport sink   (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, output ready);
endinterface

### sv/lav_rsp_if.sv
// Response channel: one matrix row per word.
`timescale 1ns / 1ps
interface lav_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]         row_index;
	logic signed [31:0] col_0;
	logic signed [31:0] col_1;
	logic signed [31:0] col_2;
	logic signed [31:0] col_3;
	logic               last_row;

	modport source (output valid, row_index, col_0, col_1, col_2, col_3, last_row, input ready);
	modport sink   (input valid, row_index, col_0, col_1, col_2, col_3, last_row, output ready);
endinterface

### sv/look_at_view_matrix_top.sv
// Top level of the look-at view matrix block.
`timescale 1ns / 1ps
// Takes an eye point and a target point (signed fixed point, FRAC_BITS
// fraction bits) on req and returns the left-handed 4x4 view matrix on rsp
// as four row words, rows 0 to 3 in order, last_row set on row 3. Forward is
// the normalised target minus eye, side the normalised (-fz, 0, fx) or
// (1,0,0) when that is zero, up is forward cross side, and row 3 holds the
// negated dot products of the axes with the eye. Everything is one pipeline
// with no per-item state: a point pair may enter in any cycle in which the
// row serialiser at the end is free, so the sustained rate is set by the
// single row-wide output port, which hands out the four rows in turn. The
// two normalisers, each a 31-stage square root and a FRAC_BITS+1 stage
// divider, make up most of the pipeline depth. A stall on rsp, once the last
// stage is full, freezes the whole pipeline; nothing is dropped or repeated.
module look_at_view_matrix_top
	import lav_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lav_req_if.sink   req,
	lav_rsp_if.source rsp
);

	localparam int UW   = FRAC_BITS + 2;      // unit axis width
	localparam int AW   = FRAC_BITS + 3;      // axis width once up is formed
	localparam int PW   = 2 * UW;             // cross product width
	localparam int PD   = AW + WORD_W;        // dot product term width
	localparam int EYEW = 3 * WORD_W;
	localparam int SBW  = EYEW + 3 * UW;

	localparam logic signed [UW-1:0] ONE_U  = {2'b01, {FRAC_BITS{1'b0}}};
	localparam word_t                ONE_W  = word_t'(ONE_U);

	// divide by 2^FRAC_BITS, round half away from zero
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
		logic [63:0] m;
		logic [63:0] q;
		m = v[63] ? $unsigned(-v) : $unsigned(v);
		q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[63] ? -$signed(q) : $signed(q);
	endfunction

	function automatic word_t sat(input logic signed [63:0] v);
		if (v > WORD_MAX) return word_t'(WORD_MAX);
		if (v < WORD_MIN) return word_t'(WORD_MIN);
		return word_t'(v);
	endfunction

	logic en;
	logic busy_q;
	row_t row_q;
	logic v_s7;

	// whole pipeline advances unless the last stage is full and the
	// serialiser cannot take it
	assign en        = !v_s7 || !busy_q || (rsp.ready && row_q == ROW_LAST);
	assign req.ready = en;

	// stage 1: register inputs, form target minus eye
	logic  v_s1;
	word_t eye_s1 [3];
	wide_t d_s1   [3];

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1[0] <= req.eye_x;
			eye_s1[1] <= req.eye_y;
			eye_s1[2] <= req.eye_z;
			d_s1[0]   <= wide_t'(req.aim_x) - wide_t'(req.eye_x);
			d_s1[1]   <= wide_t'(req.aim_y) - wide_t'(req.eye_y);
			d_s1[2]   <= wide_t'(req.aim_z) - wide_t'(req.eye_z);
		end
	end

	// forward axis
	logic                  fa_v;
	logic signed [UW-1:0]  fa [3];
	logic                  fa_zero;
	logic [EYEW-1:0]       fa_side;

	lav_unit #(.FRAC_BITS(FRAC_BITS), .SIDE_W(EYEW)) u_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.vec      (d_s1),
		.side_in  ({eye_s1[0], eye_s1[1], eye_s1[2]}),
		.out_valid(fa_v),
		.axis     (fa),
		.zero     (fa_zero),
		.side_out (fa_side)
	);

	// side axis from (-fz, 0, fx); a zero forward axis also lands on the
	// zero-length fallback below
	wide_t           sr [3];
	logic            sb_v;
	logic signed [UW-1:0] sb [3];
	logic            sb_zero;
	logic [SBW-1:0]  sb_side;

	assign sr[0] = fa_zero ? '0 : wide_t'(-fa[2]);
	assign sr[1] = '0;
	assign sr[2] = fa_zero ? '0 : wide_t'(fa[0]);

	lav_unit #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SBW)) u_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fa_v),
		.vec      (sr),
		.side_in  ({fa_side, fa[0], fa[1], fa[2]}),
		.out_valid(sb_v),
		.axis     (sb),
		.zero     (sb_zero),
		.side_out (sb_side)
	);

	// stage 2: pick side fallback, unpack sideband
	logic                 v_s2;
	logic signed [UW-1:0] f_s2 [3];
	logic signed [UW-1:0] s_s2 [3];
	word_t                eye_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				f_s2[i]   <= sb_side[(2-i)*UW +: UW];
				eye_s2[i] <= sb_side[3*UW + (2-i)*WORD_W +: WORD_W];
			end
			if (sb_zero) begin
				s_s2[0] <= ONE_U;
				s_s2[1] <= '0;
				s_s2[2] <= '0;
			end else begin
				s_s2 <= sb;
			end
		end
	end

	// stage 3: cross product terms (side y is always zero)
	logic                 v_s3;
	logic signed [PW-1:0] p0_s3, p1a_s3, p1b_s3, p2_s3;
	logic signed [UW-1:0] f_s3 [3];
	logic signed [UW-1:0] s_s3 [3];
	word_t                eye_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s3  <= f_s2[1] * s_s2[2];
			p1a_s3 <= f_s2[2] * s_s2[0];
			p1b_s3 <= f_s2[0] * s_s2[2];
			p2_s3  <= f_s2[1] * s_s2[0];
			f_s3   <= f_s2;
			s_s3   <= s_s2;
			eye_s3 <= eye_s2;
		end
	end

	// stage 4: up axis; axes gathered as side, up, forward
	logic                 v_s4;
	logic signed [AW-1:0] ax_s4 [3][3];
	word_t                eye_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ax_s4[0][i] <= AW'(s_s3[i]);
				ax_s4[2][i] <= AW'(f_s3[i]);
			end
			ax_s4[1][0] <= AW'(rnd(64'(p0_s3)));
			ax_s4[1][1] <= AW'(rnd(64'(p1a_s3) - 64'(p1b_s3)));
			ax_s4[1][2] <= AW'(rnd(-64'(p2_s3)));
			eye_s4      <= eye_s3;
		end
	end

	// stage 5: dot product terms against the eye
	logic                 v_s5;
	logic signed [PD-1:0] dp_s5 [3][3];
	logic signed [AW-1:0] ax_s5 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				for (int i = 0; i < 3; i++)
					dp_s5[a][i] <= ax_s4[a][i] * eye_s4[i];
			ax_s5 <= ax_s4;
		end
	end

	// stage 6: sums
	logic                 v_s6;
	logic signed [63:0]   ds_s6 [3];
	logic signed [AW-1:0] ax_s6 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				ds_s6[a] <= 64'(dp_s5[a][0]) + 64'(dp_s5[a][1]) + 64'(dp_s5[a][2]);
			ax_s6 <= ax_s5;
		end
	end

	// stage 7: negate, round, saturate
	word_t                dot_s7 [3];
	logic signed [AW-1:0] ax_s7 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				dot_s7[a] <= sat(rnd(-ds_s6[a]));
			ax_s7 <= ax_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= sb_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// row serialiser: holds one matrix, hands out a row word per cycle while rsp is ready
	logic  load;
	word_t ax_q  [3][3];
	word_t dot_q [3];

	assign load = en && v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (busy_q && rsp.ready) begin
			if (row_q == ROW_LAST) busy_q <= 1'b0;
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++)
					ax_q[a][i] <= word_t'(ax_s7[a][i]);
			end
			dot_q <= dot_s7;
		end
	end

	assign rsp.valid     = busy_q;
	assign rsp.row_index = row_q;
	assign rsp.last_row  = (row_q == ROW_LAST);

	always_comb begin
		if (row_q == ROW_LAST) begin
			rsp.col_0 = dot_q[0];
			rsp.col_1 = dot_q[1];
			rsp.col_2 = dot_q[2];
			rsp.col_3 = ONE_W;
		end else begin
			rsp.col_0 = ax_q[0][row_q];
			rsp.col_1 = ax_q[1][row_q];
			rsp.col_2 = ax_q[2][row_q];
			rsp.col_3 = '0;
		end
	end

endmodule

### sv/lav_unit.sv
// Pipelined vector normaliser: scale, sum of squares, square root, divide.
`timescale 1ns / 1ps
module lav_unit
	import lav_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  wide_t                   vec [3],
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    out_valid,
	output logic signed [FRAC_BITS+1:0] axis [3],
	output logic                    zero,
	output logic [SIDE_W-1:0]       side_out
);

	localparam int UW     = FRAC_BITS + 2;
	localparam int DSTEPS = FRAC_BITS + 1;
	localparam int NW     = NORM_W + FRAC_BITS + 1;
	localparam int LAT    = 6 + SQRT_STEPS + 1 + DSTEPS + 1;

	typedef struct packed {
		logic [2:0]             neg;
		logic                   zero;
		logic [2:0][NORM_W-1:0] nm;
	} lane_t;

	// valid and sideband travel in lockstep with the data
	logic              v_s  [LAT];
	logic [SIDE_W-1:0] sd_s [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < LAT; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_in;
			for (int k = 1; k < LAT; k++) sd_s[k] <= sd_s[k-1];
		end
	end

	assign out_valid = v_s[LAT-1];
	assign side_out  = sd_s[LAT-1];

	// magnitudes, maximum, common shift
	logic [MAG_W-1:0]  mag_s1 [3];
	logic [2:0]        neg_s1;
	logic [MAG_W-1:0]  mag_s2 [3];
	logic [MAG_W-1:0]  max_s2;
	logic [2:0]        neg_s2;
	logic [MAG_W-1:0]  mag_s3 [3];
	logic [2:0]        neg_s3;
	logic              zero_s3;
	logic [1:0]        rsh_s3;
	logic [4:0]        lsh_s3;
	lane_t             ln_s4;
	logic [2*NORM_W-1:0] sq_s5 [3];
	lane_t             ln_s5;
	logic [RAD_W-1:0]  sum_s6;
	lane_t             ln_s6;

	logic [5:0]        msb;
	logic [MAG_W-1:0]  mx;

	always_comb begin
		mx = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
	end

	always_comb begin
		msb = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (max_s2[b]) msb = 6'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= vec[i][MAG_W-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
				neg_s1[i] <= vec[i][MAG_W-1];
			end
			mag_s2 <= mag_s1;
			max_s2 <= mx;
			neg_s2 <= neg_s1;

			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= (max_s2 == '0);
			rsh_s3  <= (msb > 6'(NORM_MSB)) ? 2'(msb - 6'(NORM_MSB)) : 2'd0;
			lsh_s3  <= (msb < 6'(NORM_MSB)) ? 5'(6'(NORM_MSB) - msb) : 5'd0;

			ln_s4.neg  <= neg_s3;
			ln_s4.zero <= zero_s3;
			for (int i = 0; i < 3; i++)
				ln_s4.nm[i] <= NORM_W'((mag_s3[i] >> rsh_s3) << lsh_s3);

			ln_s5 <= ln_s4;
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= ln_s4.nm[i] * ln_s4.nm[i];

			ln_s6  <= ln_s5;
			sum_s6 <= RAD_W'(sq_s5[0]) + RAD_W'(sq_s5[1]) + RAD_W'(sq_s5[2]);
		end
	end

	// square root, one result bit per stage
	logic [ROOT_W-1:0] rt_s  [1:SQRT_STEPS];
	logic [MAG_W-1:0]  rm_s  [1:SQRT_STEPS];
	logic [RAD_W-1:0]  rad_s [1:SQRT_STEPS];
	lane_t             sl_s  [1:SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [ROOT_W-1:0] rt_in;
		logic [MAG_W-1:0]  rm_in;
		logic [RAD_W-1:0]  rad_in;
		lane_t             ln_in;
		logic [MAG_W+1:0]  r2;
		logic [MAG_W+1:0]  trial;

		if (j == 0) begin : g_first
			assign rt_in  = '0;
			assign rm_in  = '0;
			assign rad_in = sum_s6;
			assign ln_in  = ln_s6;
		end else begin : g_next
			assign rt_in  = rt_s[j];
			assign rm_in  = rm_s[j];
			assign rad_in = rad_s[j];
			assign ln_in  = sl_s[j];
		end

		assign r2    = {rm_in, rad_in[RAD_W-1-2*j -: 2]};
		assign trial = {2'b00, rt_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1] <= rad_in;
				sl_s[j+1]  <= ln_in;
				if (r2 >= trial) begin
					rm_s[j+1] <= MAG_W'(r2 - trial);
					rt_s[j+1] <= {rt_in[ROOT_W-2:0], 1'b1};
				end else begin
					rm_s[j+1] <= r2[MAG_W-1:0];
					rt_s[j+1] <= {rt_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// restoring division, three lanes, one quotient bit per stage
	logic [ROOT_W-1:0] dl_s [DSTEPS+1];
	logic [ROOT_W:0]   dr_s [DSTEPS+1][3];
	logic [DSTEPS-1:0] lo_s [DSTEPS+1][3];
	logic [DSTEPS-1:0] q_s  [DSTEPS+1][3];
	lane_t             dn_s [DSTEPS+1];

	logic [NW-1:0] num [3];
	logic [ROOT_W-1:0] len;

	assign len = rt_s[SQRT_STEPS];

	always_comb begin
		for (int i = 0; i < 3; i++)
			num[i] = NW'({sl_s[SQRT_STEPS].nm[i], {FRAC_BITS{1'b0}}}) + NW'(len >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= len;
			dn_s[0] <= sl_s[SQRT_STEPS];
			for (int i = 0; i < 3; i++) begin
				dr_s[0][i] <= (ROOT_W+1)'(num[i][NW-1:DSTEPS]);
				lo_s[0][i] <= num[i][DSTEPS-1:0];
				q_s[0][i]  <= '0;
			end
		end
	end

	for (genvar k = 0; k < DSTEPS; k++) begin : g_div
		logic [ROOT_W:0] r2 [3];

		always_comb begin
			for (int i = 0; i < 3; i++)
				r2[i] = {dr_s[k][i][ROOT_W-1:0], lo_s[k][i][DSTEPS-1-k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dl_s[k+1] <= dl_s[k];
				dn_s[k+1] <= dn_s[k];
				for (int i = 0; i < 3; i++) begin
					lo_s[k+1][i] <= lo_s[k][i];
					if (r2[i] >= {1'b0, dl_s[k]}) begin
						dr_s[k+1][i] <= r2[i] - {1'b0, dl_s[k]};
						q_s[k+1][i]  <= {q_s[k][i][DSTEPS-2:0], 1'b1};
					end else begin
						dr_s[k+1][i] <= r2[i];
						q_s[k+1][i]  <= {q_s[k][i][DSTEPS-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero <= dn_s[DSTEPS].zero;
			for (int i = 0; i < 3; i++) begin
				if (dn_s[DSTEPS].zero)
					axis[i] <= '0;
				else if (dn_s[DSTEPS].neg[i])
					axis[i] <= -$signed(UW'(q_s[DSTEPS][i]));
				else
					axis[i] <= $signed(UW'(q_s[DSTEPS][i]));
			end
		end
	end

endmodule
